[rtl/hcdi_pkg.sv]
// Shared types and constants for the hash chain directory indexer.
package hcdi_pkg;

  localparam int NAME_W        = 64;
  localparam int IDX_W         = 14;
  localparam int BUCKET_W      = 13;
  localparam int HASH_W        = 16;
  localparam int HASH_BITS_W   = 4;
  localparam int FOLD_W        = 32;
  localparam int K_W           = 5;

  localparam int BUCKET_DEPTH_DEFAULT = 8192;
  localparam int ENTRY_DEPTH_DEFAULT  = 16384;

  localparam logic [FOLD_W-1:0]      HASH_MULT       = 32'hE20B7AC6;
  localparam logic [HASH_BITS_W-1:0] HASH_BITS_RESET = 4'd6;
  localparam logic [K_W-1:0]         MIN_HASH_BITS   = 5'd6;
  localparam logic [IDX_W-1:0]       ROOT_IDX        = 14'd1;

  typedef struct packed {
    logic clear;
    logic load;
    logic sum;
    logic fold;
    logic mul;
    logic read;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

[rtl/hcdi_ctrl.sv]
// Sequencing state machine for the hash chain directory indexer.
module hcdi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hcdi_pkg::stat_t stat,
  output hcdi_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_FOLD  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_READ  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  a_clear_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && stat.clear_last) |=> (state == S_IDLE))
    else $error("clearing pass did not hand over to idle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new request taken while one is in flight");

endmodule

[rtl/hcdi_datapath.sv]
// Hash, table memories and result register for the hash chain directory indexer.
module hcdi_datapath #(
  parameter int BUCKET_DEPTH = hcdi_pkg::BUCKET_DEPTH_DEFAULT,
  parameter int ENTRY_DEPTH  = hcdi_pkg::ENTRY_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hcdi_pkg::cmd_t                      cmd,
  output hcdi_pkg::stat_t                     stat,
  input  logic                                cfg_wr_en,
  input  logic [hcdi_pkg::HASH_BITS_W-1:0]    cfg_wr_data,
  input  logic [hcdi_pkg::NAME_W-1:0]         name_word0,
  input  logic [hcdi_pkg::NAME_W-1:0]         name_word1,
  input  logic [hcdi_pkg::NAME_W-1:0]         name_word2,
  input  logic [hcdi_pkg::NAME_W-1:0]         name_word3,
  input  logic [hcdi_pkg::IDX_W-1:0]          parent_dir,
  input  logic [hcdi_pkg::IDX_W-1:0]          entry_index,
  input  logic                                special_name,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hcdi_pkg::BUCKET_W-1:0]       bucket,
  output logic [hcdi_pkg::IDX_W-1:0]          chain_next,
  output logic [hcdi_pkg::IDX_W-1:0]          sibling_next,
  output logic                                linked
);

  localparam int BA   = $clog2(BUCKET_DEPTH);
  localparam int EA   = $clog2(ENTRY_DEPTH);
  localparam int MAXD = (BUCKET_DEPTH > ENTRY_DEPTH) ? BUCKET_DEPTH : ENTRY_DEPTH;
  localparam int CW   = $clog2(MAXD);
  localparam int KMAX = $clog2(BUCKET_DEPTH + 1) - 1;

  logic [hcdi_pkg::IDX_W-1:0]       bucket_mem [BUCKET_DEPTH];
  logic [hcdi_pkg::IDX_W-1:0]       child_mem  [ENTRY_DEPTH];

  logic [hcdi_pkg::HASH_BITS_W-1:0] hash_bits;
  logic [CW-1:0]                    clr_cnt;

  logic [hcdi_pkg::NAME_W-1:0]      w0, w1, w2, w3;
  logic [hcdi_pkg::IDX_W-1:0]       parent_q;
  logic [hcdi_pkg::IDX_W-1:0]       entry_q;
  logic                             special_q;
  logic [hcdi_pkg::NAME_W-1:0]      sum_a, sum_b;
  logic [hcdi_pkg::FOLD_W-1:0]      fold_q;
  logic [hcdi_pkg::HASH_W-1:0]      hash_q;
  logic [hcdi_pkg::HASH_W-1:0]      bucket_q;
  logic                             linked_q;
  logic [hcdi_pkg::IDX_W-1:0]       bucket_rd;
  logic [hcdi_pkg::IDX_W-1:0]       child_rd;

  logic [hcdi_pkg::NAME_W-1:0]      sum_all;
  logic [2*hcdi_pkg::FOLD_W-1:0]    prod;
  logic [hcdi_pkg::K_W-1:0]         k_raw;
  logic [hcdi_pkg::K_W-1:0]         k_eff;
  logic [hcdi_pkg::HASH_W:0]        mask_full;
  logic [hcdi_pkg::HASH_W-1:0]      hash_masked;
  logic [EA-1:0]                    child_addr;
  logic                             link_ok;

  assign sum_all = sum_a + sum_b;
  assign prod    = {{hcdi_pkg::FOLD_W{1'b0}}, fold_q} *
                   {{hcdi_pkg::FOLD_W{1'b0}}, hcdi_pkg::HASH_MULT};

  assign k_raw = {1'b0, hash_bits};
  always_comb begin
    priority if (k_raw < hcdi_pkg::MIN_HASH_BITS) begin
      k_eff = hcdi_pkg::MIN_HASH_BITS;
    end else if (k_raw > hcdi_pkg::K_W'(KMAX)) begin
      k_eff = hcdi_pkg::K_W'(KMAX);
    end else begin
      k_eff = k_raw;
    end
  end

  assign mask_full   = ({{hcdi_pkg::HASH_W{1'b0}}, 1'b1} << k_eff) - 1'b1;
  assign hash_masked = hash_q & mask_full[hcdi_pkg::HASH_W-1:0];
  assign child_addr  = EA'(parent_q);
  assign link_ok     = (entry_q != hcdi_pkg::ROOT_IDX) && (parent_q != hcdi_pkg::ROOT_IDX) &&
                       (entry_q != parent_q) && !special_q &&
                       (32'(parent_q) < ENTRY_DEPTH);

  assign stat.clear_last = (clr_cnt == CW'(MAXD - 1));
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_bits <= hcdi_pkg::HASH_BITS_RESET;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hash_bits <= cfg_wr_data;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w0        <= name_word0;
      w1        <= name_word1;
      w2        <= name_word2;
      w3        <= name_word3;
      parent_q  <= parent_dir;
      entry_q   <= entry_index;
      special_q <= special_name;
    end
    if (cmd.sum) begin
      sum_a <= w0 + w1;
      sum_b <= w2 + w3 + hcdi_pkg::NAME_W'(parent_q);
    end
    if (cmd.fold) begin
      fold_q <= sum_all[hcdi_pkg::FOLD_W-1:0] + sum_all[hcdi_pkg::NAME_W-1:hcdi_pkg::FOLD_W];
    end
    if (cmd.mul) begin
      hash_q <= prod[hcdi_pkg::FOLD_W+hcdi_pkg::HASH_W-1:hcdi_pkg::FOLD_W];
    end
    if (cmd.read) begin
      bucket_q <= hash_masked;
      linked_q <= link_ok;
    end
    if (cmd.finish) begin
      bucket       <= hcdi_pkg::BUCKET_W'(bucket_q);
      chain_next   <= bucket_rd;
      sibling_next <= linked_q ? child_rd : '0;
      linked       <= linked_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      bucket_rd <= bucket_mem[hash_masked[BA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      child_rd <= child_mem[child_addr];
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.clear) begin
      if (32'(clr_cnt) < BUCKET_DEPTH) begin
        bucket_mem[clr_cnt[BA-1:0]] <= '0;
      end
    end else if (cmd.finish) begin
      bucket_mem[bucket_q[BA-1:0]] <= entry_q;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.clear) begin
      if (32'(clr_cnt) < ENTRY_DEPTH) begin
        child_mem[clr_cnt[EA-1:0]] <= '0;
      end
    end else if (cmd.finish && linked_q) begin
      child_mem[child_addr] <= entry_q;
    end
  end

  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten while still held");

  a_unlinked_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !linked) |-> (sibling_next == '0))
    else $error("sibling link reported for an unlinked entry");

endmodule

[rtl/hash_chain_directory_indexer_core.sv]
// Top level of the hash chain directory indexer.
// Each request carries one directory entry; its name words and parent index are summed,
// folded, hashed by a constant multiply and masked to 2^hash_bits buckets (hash_bits clamped
// to 6..log2(BUCKET_DEPTH)), and the entry is prepended to that bucket chain and, when
// eligible, to its parent's child list. A request passes through the sum, fold, multiply, table
// read and table write steps of the sequencer before its result is valid, and the next one is
// taken only after the table write; the result register lets the next request enter while a
// result waits. After reset both tables are cleared one entry per cycle, until the clear counter
// has covered the deeper table, during which in_ready stays low; hash_bits may be written at
// any time the block is idle.
module hash_chain_directory_indexer_core #(
  parameter int BUCKET_DEPTH = hcdi_pkg::BUCKET_DEPTH_DEFAULT,
  parameter int ENTRY_DEPTH  = hcdi_pkg::ENTRY_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [hcdi_pkg::HASH_BITS_W-1:0] cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hcdi_pkg::NAME_W-1:0]      name_word0,
  input  logic [hcdi_pkg::NAME_W-1:0]      name_word1,
  input  logic [hcdi_pkg::NAME_W-1:0]      name_word2,
  input  logic [hcdi_pkg::NAME_W-1:0]      name_word3,
  input  logic [hcdi_pkg::IDX_W-1:0]       parent_dir,
  input  logic [hcdi_pkg::IDX_W-1:0]       entry_index,
  input  logic                             special_name,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hcdi_pkg::BUCKET_W-1:0]    bucket,
  output logic [hcdi_pkg::IDX_W-1:0]       chain_next,
  output logic [hcdi_pkg::IDX_W-1:0]       sibling_next,
  output logic                             linked
);

  hcdi_pkg::cmd_t  cmd;
  hcdi_pkg::stat_t stat;

  hcdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hcdi_datapath #(
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .ENTRY_DEPTH  (ENTRY_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .name_word0   (name_word0),
    .name_word1   (name_word1),
    .name_word2   (name_word2),
    .name_word3   (name_word3),
    .parent_dir   (parent_dir),
    .entry_index  (entry_index),
    .special_name (special_name),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bucket       (bucket),
    .chain_next   (chain_next),
    .sibling_next (sibling_next),
    .linked       (linked)
  );

endmodule

[sim/hash_chain_directory_indexer_checker.sv]
// Checker for the hash chain directory indexer: predicts each result and compares it.
module hash_chain_directory_indexer_checker
  import hcdi_pkg::*;
#(
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEFAULT,
  parameter int ENTRY_DEPTH  = ENTRY_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [HASH_BITS_W-1:0] cfg_wr_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [NAME_W-1:0]      name_word0,
  input  logic [NAME_W-1:0]      name_word1,
  input  logic [NAME_W-1:0]      name_word2,
  input  logic [NAME_W-1:0]      name_word3,
  input  logic [IDX_W-1:0]       parent_dir,
  input  logic [IDX_W-1:0]       entry_index,
  input  logic                   special_name,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [BUCKET_W-1:0]    bucket,
  input  logic [IDX_W-1:0]       chain_next,
  input  logic [IDX_W-1:0]       sibling_next,
  input  logic                   linked,
  output int                     mismatches,
  output int                     outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [IDX_W-1:0]    chain_next;
    logic [IDX_W-1:0]    sibling_next;
    logic                linked;
  } link_result_t;

  logic [IDX_W-1:0]       bucket_head_mem [BUCKET_DEPTH];
  logic [IDX_W-1:0]       child_head_mem  [ENTRY_DEPTH];
  logic [HASH_BITS_W-1:0] hash_bits_q;
  link_result_t           pending_links [$];
  link_result_t           oldest;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int max_exponent();
    int k;
    k = 0;
    while (k < 31 && (64'd1 << (k + 1)) <= BUCKET_DEPTH) k++;
    return k;
  endfunction

  function automatic logic [HASH_W-1:0] name_hash(input logic [NAME_W-1:0] w0,
                                                  input logic [NAME_W-1:0] w1,
                                                  input logic [NAME_W-1:0] w2,
                                                  input logic [NAME_W-1:0] w3,
                                                  input logic [IDX_W-1:0]  parent);
    logic [63:0] total;
    logic [31:0] folded;
    logic [63:0] product;
    total   = w0 + w1 + w2 + w3 + 64'(parent);
    folded  = total[31:0] + total[63:32];
    product = 64'(folded) * 64'(HASH_MULT);
    return product[47:32];
  endfunction

  function automatic link_result_t insert_entry(input logic [NAME_W-1:0] w0,
                                                input logic [NAME_W-1:0] w1,
                                                input logic [NAME_W-1:0] w2,
                                                input logic [NAME_W-1:0] w3,
                                                input logic [IDX_W-1:0]  parent,
                                                input logic [IDX_W-1:0]  entry,
                                                input logic              special);
    link_result_t res;
    int           k;
    logic [31:0]  b;
    k = int'(hash_bits_q);
    if (k < int'(MIN_HASH_BITS)) k = int'(MIN_HASH_BITS);
    if (k > max_exponent()) k = max_exponent();
    b = 32'(name_hash(w0, w1, w2, w3, parent)) & ((32'd1 << k) - 32'd1);
    if (b >= BUCKET_DEPTH) b = 0;
    res.bucket         = b[BUCKET_W-1:0];
    res.chain_next     = bucket_head_mem[b];
    bucket_head_mem[b] = entry;
    res.sibling_next   = '0;
    res.linked         = 1'b0;
    if (entry != ROOT_IDX && parent != ROOT_IDX && entry != parent && !special &&
        int'(parent) < ENTRY_DEPTH) begin
      res.sibling_next       = child_head_mem[parent];
      child_head_mem[parent] = entry;
      res.linked             = 1'b1;
    end
    return res;
  endfunction

  task automatic clear_tables();
    for (int i = 0; i < BUCKET_DEPTH; i++) bucket_head_mem[i] = '0;
    for (int i = 0; i < ENTRY_DEPTH; i++) child_head_mem[i] = '0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
      pending_links.delete();
      hash_bits_q = HASH_BITS_RESET;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) hash_bits_q = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (pending_links.size() == 0) begin
          report_mismatch("unrequested result, bucket", int'(bucket), -1);
        end else begin
          oldest = pending_links.pop_front();
          if (bucket !== oldest.bucket)
            report_mismatch("bucket", int'(bucket), int'(oldest.bucket));
          if (chain_next !== oldest.chain_next)
            report_mismatch("chain_next", int'(chain_next), int'(oldest.chain_next));
          if (sibling_next !== oldest.sibling_next)
            report_mismatch("sibling_next", int'(sibling_next), int'(oldest.sibling_next));
          if (linked !== oldest.linked)
            report_mismatch("linked", int'(linked), int'(oldest.linked));
        end
      end
      if (in_valid && in_ready)
        pending_links.push_back(insert_entry(name_word0, name_word1, name_word2, name_word3,
                                             parent_dir, entry_index, special_name));
      outstanding <= pending_links.size();
    end
  end

endmodule

[sim/hash_chain_directory_indexer_core_tb.sv]
// Testbench top for the hash chain directory indexer: stimulus, flow control and verdict.
module hash_chain_directory_indexer_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import hcdi_pkg::*;

  localparam int BUCKETS     = BUCKET_DEPTH_DEFAULT;
  localparam int ENTRIES     = ENTRY_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 12;

  typedef struct packed {
    logic [NAME_W-1:0] w0;
    logic [NAME_W-1:0] w1;
    logic [NAME_W-1:0] w2;
    logic [NAME_W-1:0] w3;
    logic [IDX_W-1:0]  parent;
    logic [IDX_W-1:0]  entry;
    logic              special;
  } dir_entry_t;

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   cfg_wr_en    = 1'b0;
  logic [HASH_BITS_W-1:0] cfg_wr_data  = '0;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic [NAME_W-1:0]      name_word0   = '0;
  logic [NAME_W-1:0]      name_word1   = '0;
  logic [NAME_W-1:0]      name_word2   = '0;
  logic [NAME_W-1:0]      name_word3   = '0;
  logic [IDX_W-1:0]       parent_dir   = '0;
  logic [IDX_W-1:0]       entry_index  = '0;
  logic                   special_name = 1'b0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic [BUCKET_W-1:0]    bucket;
  logic [IDX_W-1:0]       chain_next;
  logic [IDX_W-1:0]       sibling_next;
  logic                   linked;

  int fail_count;
  int pending;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  logic [IDX_W-1:0]  next_entry = '1;
  logic [NAME_W-1:0] last_name [4] = '{default: '0};

  hash_chain_directory_indexer_core #(
    .BUCKET_DEPTH(BUCKETS),
    .ENTRY_DEPTH (ENTRIES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .name_word0  (name_word0),
    .name_word1  (name_word1),
    .name_word2  (name_word2),
    .name_word3  (name_word3),
    .parent_dir  (parent_dir),
    .entry_index (entry_index),
    .special_name(special_name),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bucket      (bucket),
    .chain_next  (chain_next),
    .sibling_next(sibling_next),
    .linked      (linked)
  );

  hash_chain_directory_indexer_checker #(
    .BUCKET_DEPTH(BUCKETS),
    .ENTRY_DEPTH (ENTRIES)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .name_word0  (name_word0),
    .name_word1  (name_word1),
    .name_word2  (name_word2),
    .name_word3  (name_word3),
    .parent_dir  (parent_dir),
    .entry_index (entry_index),
    .special_name(special_name),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bucket      (bucket),
    .chain_next  (chain_next),
    .sibling_next(sibling_next),
    .linked      (linked),
    .mismatches  (fail_count),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // hold off the result side for a long stretch on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_left   <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic dir_entry_t mk(input logic [NAME_W-1:0] w0, input logic [NAME_W-1:0] w1,
                                    input logic [NAME_W-1:0] w2, input logic [NAME_W-1:0] w3,
                                    input logic [IDX_W-1:0] parent,
                                    input logic [IDX_W-1:0] entry, input logic special);
    dir_entry_t e;
    e = '{w0, w1, w2, w3, parent, entry, special};
    return e;
  endfunction

  function automatic logic [NAME_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_entry(input dir_entry_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    name_word0   <= e.w0;
    name_word1   <= e.w1;
    name_word2   <= e.w2;
    name_word3   <= e.w3;
    parent_dir   <= e.parent;
    entry_index  <= e.entry;
    special_name <= e.special;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_hash_bits(input logic [HASH_BITS_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic make_entry(output dir_entry_t e);
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      e.w0 = last_name[0];
      e.w1 = last_name[1];
      e.w2 = last_name[2];
      e.w3 = last_name[3];
    end else begin
      e.w0 = rand_word();
      e.w1 = rand_word();
      e.w2 = rand_word();
      e.w3 = rand_word();
    end
    last_name[0] = e.w0;
    last_name[1] = e.w1;
    last_name[2] = e.w2;
    last_name[3] = e.w3;
    pick = $urandom_range(99);
    if (pick < 70)      e.parent = IDX_W'($urandom_range(20, 2));
    else if (pick < 90) e.parent = IDX_W'($urandom);
    else if (pick < 94) e.parent = '0;
    else if (pick < 97) e.parent = ROOT_IDX;
    else                e.parent = '1;
    e.entry = next_entry;
    next_entry = next_entry - 1'b1;
    pick = $urandom_range(99);
    if (pick < 4)      e.entry = IDX_W'($urandom);
    else if (pick < 8) e.entry = e.parent;
    else if (pick < 11) e.entry = ROOT_IDX;
    e.special = ($urandom_range(99) < 10);
    if (e.special && $urandom_range(99) < 80) e.parent = ROOT_IDX;
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
                           input logic [HASH_BITS_W-1:0] hb, input bit with_pressure);
    dir_entry_t e;
    wait_drained();
    write_hash_bits(hb);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    for (int i = 0; i < n; i++) begin
      if (with_pressure && i == n / 2) hold_requests <= hold_requests + 1;
      if (with_pressure && i == (3 * n) / 4) wait_drained();
      make_entry(e);
      send_entry(e);
    end
    wait_drained();
  endtask

  initial begin
    dir_entry_t directed [$];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!in_ready);

    // special cases at the reset hash size, then at the widest
    directed.push_back(mk('0, '0, '0, '0, 14'd0, 14'd16383, 1'b0));
    directed.push_back(mk('1, '1, '1, '1, 14'd16383, 14'd16382, 1'b0));
    directed.push_back(mk('1, '1, '1, '1, 14'd16383, 14'd16381, 1'b0));
    directed.push_back(mk(64'hFFFFFFFF_00000000, 64'h00000000_FFFFFFFF, '0, '0,
                          14'd0, 14'd16380, 1'b0));
    directed.push_back(mk({16{4'h5}}, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}, 14'd5, ROOT_IDX, 1'b0));
    directed.push_back(mk(64'd42, '0, '0, '0, ROOT_IDX, 14'd100, 1'b0));
    directed.push_back(mk(64'd7, 64'd7, '0, '0, 14'd7, 14'd7, 1'b0));
    directed.push_back(mk(64'h24, '0, '0, '0, ROOT_IDX, 14'd50, 1'b1));
    directed.push_back(mk(64'h2424, '0, '0, '0, 14'd9, 14'd51, 1'b1));
    directed.push_back(mk('0, '0, '0, '0, 14'd0, 14'd0, 1'b0));
    directed.push_back(mk({16{4'hA}}, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}, 14'd9, 14'd52, 1'b0));
    directed.push_back(mk('0, '0, '0, '0, 14'd16383, 14'd0, 1'b0));
    foreach (directed[i]) send_entry(directed[i]);
    wait_drained();
    write_hash_bits(4'd13);
    directed.delete();
    directed.push_back(mk('1, '1, '1, '1, 14'd16383, 14'd20, 1'b0));
    directed.push_back(mk('1, '1, '1, '1, 14'd16383, 14'd19, 1'b0));
    directed.push_back(mk(64'hFFFFFFFF_00000000, 64'h00000000_FFFFFFFF, '0, '0,
                          14'd0, 14'd18, 1'b0));
    directed.push_back(mk('0, '0, '0, '1, 14'd16383, 14'd16383, 1'b0));
    directed.push_back(mk('1, '0, '1, '0, ROOT_IDX, ROOT_IDX, 1'b1));
    foreach (directed[i]) send_entry(directed[i]);

    run_phase(250, 0, 0, 4'd15, 1'b1);
    run_phase(250, 45, 0, 4'd0, 1'b0);
    run_phase(250, 0, 45, 4'd9, 1'b0);
    run_phase(250, 29, 29, 4'd5, 1'b0);
    run_phase(250, 0, 0, 4'd13, 1'b0);
    run_phase(250, 45, 0, 4'd14, 1'b0);
    run_phase(250, 0, 45, 4'd6, 1'b0);
    run_phase(250, 29, 29, 4'd11, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
